### hw/rtl/isingm_pkg.sv
package isingm_pkg;

	localparam int SIDE_DEFAULT = 64;
	localparam int SITE_W       = 12;
	localparam int FRAC_W       = 32;
	localparam int THR_W        = 33;
	localparam int ENERGY_W     = 15;
	localparam int ENERGY_MIN   = -16384;
	localparam int ENERGY_MAX   = 16383;
	localparam int NUM_THR      = 4;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_ADDR_W   = $clog2(NUM_THR * 8);

	localparam logic [THR_W-1:0] THR_RESET = {1'b1, {(THR_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_WRITE     = 2'd0,
		OP_RECOMPUTE = 2'd1,
		OP_ATTEMPT   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_THR_M4 = 2'd0,
		REG_THR_M2 = 2'd1,
		REG_THR_P2 = 2'd2,
		REG_THR_P4 = 2'd3
	} thr_reg_t;

	typedef logic [NUM_THR-1:0][THR_W-1:0] thr_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_DIV,
		ST_NBR,
		ST_DECIDE,
		ST_SWEEP,
		ST_PEEK,
		ST_FETCH,
		ST_DONE
	} state_t;

endpackage

### hw/rtl/ising_metropolis_spin_update.sv
// Metropolis spin update for a SIDE x SIDE toroidal Ising lattice held in one
// single-port spin RAM (one read or write per cycle) plus a running energy.
// After reset the block stalls its input while it sets every spin to +1;
// threshold registers can be written during that pass. A flip attempt makes
// five spin reads through the single RAM port, then the decision and
// write-back; a recompute makes three reads per site (the site, its right and
// its down neighbor). One item is in flight at a time; a new item is taken
// while the previous result still sits in the output register.
module ising_metropolis_spin_update #(
	parameter int SIDE = isingm_pkg::SIDE_DEFAULT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [1:0]                               operation,
	input  logic [isingm_pkg::SITE_W-1:0]            site,
	input  logic                                     spin_value,
	input  logic [isingm_pkg::FRAC_W-1:0]            random_fraction,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic                                     accepted,
	output logic                                     spin_after,
	output logic signed [isingm_pkg::ENERGY_W-1:0]   energy,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [isingm_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [isingm_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [isingm_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                     pready
);

	localparam int SITES = SIDE * SIDE;
	localparam int AW    = $clog2(SITES);

	isingm_pkg::thr_t thr;
	logic             ram_en;
	logic             ram_we;
	logic [AW-1:0]    ram_addr;
	logic             ram_wdata;
	logic             ram_rdata;

	isingm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.thr     (thr)
	);

	isingm_spin_ram #(
		.DEPTH (SITES)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	isingm_ctrl #(
		.SIDE (SIDE)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.site            (site),
		.spin_value      (spin_value),
		.random_fraction (random_fraction),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.accepted        (accepted),
		.spin_after      (spin_after),
		.energy          (energy),
		.thr             (thr),
		.ram_en          (ram_en),
		.ram_we          (ram_we),
		.ram_addr        (ram_addr),
		.ram_wdata       (ram_wdata),
		.ram_rdata       (ram_rdata)
	);

endmodule

### hw/rtl/isingm_cfg.sv
module isingm_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [isingm_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [isingm_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [isingm_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                 pready,
	output isingm_pkg::thr_t                     thr
);

	isingm_pkg::thr_t      thr_q;
	isingm_pkg::thr_reg_t  reg_sel;
	logic                  wr_en;

	// registers sit on 8-byte boundaries
	assign reg_sel = isingm_pkg::thr_reg_t'(paddr[isingm_pkg::CFG_ADDR_W-1:3]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign thr     = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < isingm_pkg::NUM_THR; i++) begin
				thr_q[i] <= isingm_pkg::THR_RESET;
			end
		end else if (wr_en) begin
			thr_q[reg_sel] <= pwdata[isingm_pkg::THR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			isingm_pkg::REG_THR_M4: prdata[isingm_pkg::THR_W-1:0] = thr_q[isingm_pkg::REG_THR_M4];
			isingm_pkg::REG_THR_M2: prdata[isingm_pkg::THR_W-1:0] = thr_q[isingm_pkg::REG_THR_M2];
			isingm_pkg::REG_THR_P2: prdata[isingm_pkg::THR_W-1:0] = thr_q[isingm_pkg::REG_THR_P2];
			isingm_pkg::REG_THR_P4: prdata[isingm_pkg::THR_W-1:0] = thr_q[isingm_pkg::REG_THR_P4];
			default:                prdata = '0;
		endcase
	end

endmodule

### hw/rtl/isingm_spin_ram.sv
module isingm_spin_ram #(
	parameter int DEPTH = isingm_pkg::SIDE_DEFAULT * isingm_pkg::SIDE_DEFAULT,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic          wdata,
	output logic          rdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

### hw/rtl/isingm_ctrl.sv
module isingm_ctrl #(
	parameter int SIDE = isingm_pkg::SIDE_DEFAULT,
	localparam int SITES = SIDE * SIDE,
	localparam int AW = $clog2(SITES)
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [1:0]                               operation,
	input  logic [isingm_pkg::SITE_W-1:0]            site,
	input  logic                                     spin_value,
	input  logic [isingm_pkg::FRAC_W-1:0]            random_fraction,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic                                     accepted,
	output logic                                     spin_after,
	output logic signed [isingm_pkg::ENERGY_W-1:0]   energy,
	input  isingm_pkg::thr_t                         thr,
	output logic                                     ram_en,
	output logic                                     ram_we,
	output logic [AW-1:0]                            ram_addr,
	output logic                                     ram_wdata,
	input  logic                                     ram_rdata
);

	localparam int SW    = isingm_pkg::SITE_W;
	localparam int EW    = isingm_pkg::ENERGY_W;
	localparam int XW    = ((AW > SW) ? AW : SW) + 1;
	localparam int RW    = $clog2(SIDE);
	localparam int PW    = SW + 32;
	localparam longint RECIP = ((longint'(1) << 32) + longint'(SIDE) - 1) / longint'(SIDE);
	localparam int DW    = $clog2(2 * SITES + 1);
	localparam int SEW   = ((DW + 2) > (EW + 1)) ? (DW + 2) : (EW + 1);
	localparam int E_RST_INT = (-2 * SITES < isingm_pkg::ENERGY_MIN) ?
		isingm_pkg::ENERGY_MIN : -2 * SITES;
	localparam logic signed [EW-1:0] ENERGY_RESET = EW'(E_RST_INT);
	localparam logic signed [EW:0]   E_MAX_A = (EW+1)'(isingm_pkg::ENERGY_MAX);
	localparam logic signed [EW:0]   E_MIN_A = (EW+1)'(isingm_pkg::ENERGY_MIN);
	localparam logic signed [SEW-1:0] E_MAX_S = SEW'(isingm_pkg::ENERGY_MAX);
	localparam logic signed [SEW-1:0] E_MIN_S = SEW'(isingm_pkg::ENERGY_MIN);
	localparam logic [2:0] NBR_LAST = 3'd4;
	localparam logic [1:0] PH_SELF  = 2'd0;
	localparam logic [1:0] PH_RIGHT = 2'd1;
	localparam logic [1:0] PH_DOWN  = 2'd2;

	isingm_pkg::state_t state_q, state_d;

	logic [1:0]          op_q;
	logic [SW-1:0]       site_q;
	logic                site_ok_q;
	logic                wval_q;
	logic [isingm_pkg::FRAC_W-1:0] frac_q;
	logic [RW-1:0]       row_q;
	logic [2:0]          idx_q;
	logic                cen_q;
	logic [2:0]          dis_q;
	logic [AW-1:0]       cur_q;
	logic [RW-1:0]       r_q;
	logic [RW-1:0]       c_q;
	logic [1:0]          ph_q;
	logic [1:0]          rd_ph_s1;
	logic                rd_vld_s1;
	logic                s_q;
	logic [DW-1:0]       dcnt_q;
	logic signed [EW-1:0] energy_q;
	logic                res_acc_q;
	logic                res_spin_q;
	logic                out_valid_q;

	logic                in_site_ok;
	logic [XW-1:0]       site_x;
	logic [AW-1:0]       site_addr;
	logic [PW-1:0]       prod;
	logic [AW-1:0]       row_base;
	logic                col_first, col_last, row_first, row_last;
	logic [AW-1:0]       right_a, left_a, up_a, down_a, nbr_addr;
	logic [AW-1:0]       right_sw, down_sw, sweep_addr;
	logic [2:0]          d_fin;
	logic [isingm_pkg::THR_W-1:0] thr_sel;
	logic                thr_always;
	logic                take;
	logic signed [EW:0]  delta, e_sum;
	logic signed [EW-1:0] e_att;
	logic signed [SEW-1:0] e_raw;
	logic signed [EW-1:0] e_sw;
	logic                load_out;
	logic                last_site;

	assign in_site_ok = XW'(site) < XW'(SITES);
	assign site_x     = XW'(site_q);
	assign site_addr  = site_x[AW-1:0];

	// row = site / SIDE by reciprocal multiply; exact for 12-bit sites
	assign prod = PW'(site_q) * PW'(RECIP);

	assign row_base  = AW'(row_q) * AW'(SIDE);
	assign col_first = site_addr == row_base;
	assign col_last  = site_addr == (row_base + AW'(SIDE - 1));
	assign row_first = row_q == '0;
	assign row_last  = row_q == RW'(SIDE - 1);

	assign right_a = col_last  ? site_addr - AW'(SIDE - 1)     : site_addr + AW'(1);
	assign left_a  = col_first ? site_addr + AW'(SIDE - 1)     : site_addr - AW'(1);
	assign up_a    = row_first ? site_addr + AW'(SITES - SIDE) : site_addr - AW'(SIDE);
	assign down_a  = row_last  ? site_addr - AW'(SITES - SIDE) : site_addr + AW'(SIDE);

	always_comb begin
		case (idx_q)
			3'd0:    nbr_addr = site_addr;
			3'd1:    nbr_addr = right_a;
			3'd2:    nbr_addr = left_a;
			3'd3:    nbr_addr = up_a;
			default: nbr_addr = down_a;
		endcase
	end

	assign last_site = cur_q == AW'(SITES - 1);
	assign right_sw  = (c_q == RW'(SIDE - 1)) ? cur_q - AW'(SIDE - 1) : cur_q + AW'(1);
	assign down_sw   = (r_q == RW'(SIDE - 1)) ? cur_q - AW'(SITES - SIDE) : cur_q + AW'(SIDE);

	always_comb begin
		case (ph_q)
			PH_SELF:  sweep_addr = cur_q;
			PH_RIGHT: sweep_addr = right_sw;
			default:  sweep_addr = down_sw;
		endcase
	end

	// d_fin counts neighbors that disagree; the down neighbor lands in DECIDE
	assign d_fin = dis_q + 3'(ram_rdata != cen_q);

	always_comb begin
		thr_sel    = '0;
		thr_always = 1'b0;
		delta      = '0;
		case (d_fin)
			3'd0: begin
				thr_sel = thr[isingm_pkg::REG_THR_P4];
				delta   = (EW+1)'(8);
			end
			3'd1: begin
				thr_sel = thr[isingm_pkg::REG_THR_P2];
				delta   = (EW+1)'(4);
			end
			3'd3: begin
				thr_sel = thr[isingm_pkg::REG_THR_M2];
				delta   = (EW+1)'(-4);
			end
			3'd4: begin
				thr_sel = thr[isingm_pkg::REG_THR_M4];
				delta   = (EW+1)'(-8);
			end
			default: begin
				thr_always = 1'b1;
			end
		endcase
	end

	assign take  = thr_always || ({1'b0, frac_q} < thr_sel);
	assign e_sum = {energy_q[EW-1], energy_q} + delta;
	assign e_att = (e_sum > E_MAX_A) ? EW'(E_MAX_A) :
		(e_sum < E_MIN_A) ? EW'(E_MIN_A) : e_sum[EW-1:0];

	// energy = 2 * disagreeing bonds - 2 * SITES
	assign e_raw = $signed(SEW'({dcnt_q, 1'b0})) - SEW'(2 * SITES);
	assign e_sw  = (e_raw > E_MAX_S) ? EW'(E_MAX_S) :
		(e_raw < E_MIN_S) ? EW'(E_MIN_S) : e_raw[EW-1:0];

	assign load_out  = (state_q == isingm_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign in_stall  = state_q != isingm_pkg::ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			isingm_pkg::ST_CLEAR: begin
				if (last_site) state_d = isingm_pkg::ST_IDLE;
			end
			isingm_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (isingm_pkg::op_t'(operation))
						isingm_pkg::OP_WRITE:
							state_d = in_site_ok ? isingm_pkg::ST_WRITE : isingm_pkg::ST_PEEK;
						isingm_pkg::OP_ATTEMPT:
							state_d = in_site_ok ? isingm_pkg::ST_DIV : isingm_pkg::ST_PEEK;
						isingm_pkg::OP_RECOMPUTE:
							state_d = isingm_pkg::ST_SWEEP;
						default:
							state_d = isingm_pkg::ST_PEEK;
					endcase
				end
			end
			isingm_pkg::ST_WRITE:  state_d = isingm_pkg::ST_DONE;
			isingm_pkg::ST_DIV:    state_d = isingm_pkg::ST_NBR;
			isingm_pkg::ST_NBR: begin
				if (idx_q == NBR_LAST) state_d = isingm_pkg::ST_DECIDE;
			end
			isingm_pkg::ST_DECIDE: state_d = isingm_pkg::ST_DONE;
			isingm_pkg::ST_SWEEP: begin
				if (ph_q == PH_DOWN && last_site) state_d = isingm_pkg::ST_PEEK;
			end
			isingm_pkg::ST_PEEK:   state_d = isingm_pkg::ST_FETCH;
			isingm_pkg::ST_FETCH:  state_d = isingm_pkg::ST_DONE;
			isingm_pkg::ST_DONE: begin
				if (load_out) state_d = isingm_pkg::ST_IDLE;
			end
			default: state_d = isingm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = site_addr;
		ram_wdata = 1'b0;
		case (state_q)
			isingm_pkg::ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = cur_q;
				ram_wdata = 1'b1;
			end
			isingm_pkg::ST_WRITE: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = wval_q;
			end
			isingm_pkg::ST_NBR: begin
				ram_en   = 1'b1;
				ram_addr = nbr_addr;
			end
			isingm_pkg::ST_DECIDE: begin
				ram_en    = take;
				ram_we    = take;
				ram_wdata = ~cen_q;
			end
			isingm_pkg::ST_SWEEP: begin
				ram_en   = 1'b1;
				ram_addr = sweep_addr;
			end
			isingm_pkg::ST_PEEK: begin
				ram_en = site_ok_q;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= isingm_pkg::ST_CLEAR;
			cur_q       <= '0;
			r_q         <= '0;
			c_q         <= '0;
			ph_q        <= PH_SELF;
			idx_q       <= '0;
			dis_q       <= '0;
			dcnt_q      <= '0;
			rd_vld_s1   <= 1'b0;
			energy_q    <= ENERGY_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= state_q == isingm_pkg::ST_SWEEP;

			case (state_q)
				isingm_pkg::ST_CLEAR: cur_q <= cur_q + AW'(1);
				isingm_pkg::ST_IDLE: begin
					if (in_valid) begin
						cur_q  <= '0;
						r_q    <= '0;
						c_q    <= '0;
						ph_q   <= PH_SELF;
						idx_q  <= '0;
						dis_q  <= '0;
						dcnt_q <= '0;
					end
				end
				isingm_pkg::ST_NBR: begin
					idx_q <= idx_q + 3'd1;
					if (idx_q != 3'd0 && idx_q != 3'd1) begin
						dis_q <= dis_q + 3'(ram_rdata != cen_q);
					end
				end
				isingm_pkg::ST_DECIDE: begin
					if (take) energy_q <= e_att;
				end
				isingm_pkg::ST_SWEEP: begin
					if (ph_q == PH_DOWN) begin
						ph_q  <= PH_SELF;
						cur_q <= cur_q + AW'(1);
						if (c_q == RW'(SIDE - 1)) begin
							c_q <= '0;
							r_q <= r_q + RW'(1);
						end else begin
							c_q <= c_q + RW'(1);
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				isingm_pkg::ST_FETCH: begin
					if (op_q == isingm_pkg::OP_RECOMPUTE) energy_q <= e_sw;
				end
				default: begin
				end
			endcase

			// bond data arrives in the cycle after its sweep address
			if (rd_vld_s1 && rd_ph_s1 != PH_SELF) begin
				dcnt_q <= dcnt_q + DW'(ram_rdata != s_q);
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_ph_s1 <= ph_q;
		if (rd_vld_s1 && rd_ph_s1 == PH_SELF) begin
			s_q <= ram_rdata;
		end
		if (state_q == isingm_pkg::ST_IDLE && in_valid) begin
			op_q      <= operation;
			site_q    <= site;
			site_ok_q <= in_site_ok;
			wval_q    <= spin_value;
			frac_q    <= random_fraction;
		end
		if (state_q == isingm_pkg::ST_DIV) begin
			row_q <= prod[32 +: RW];
		end
		if (state_q == isingm_pkg::ST_NBR && idx_q == 3'd1) begin
			cen_q <= ram_rdata;
		end
		case (state_q)
			isingm_pkg::ST_WRITE: begin
				res_acc_q  <= 1'b0;
				res_spin_q <= wval_q;
			end
			isingm_pkg::ST_DECIDE: begin
				res_acc_q  <= take;
				res_spin_q <= cen_q ^ take;
			end
			isingm_pkg::ST_FETCH: begin
				res_acc_q  <= 1'b0;
				res_spin_q <= site_ok_q & ram_rdata;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			accepted   <= res_acc_q;
			spin_after <= res_spin_q;
			energy     <= energy_q;
		end
	end

endmodule

### hw/rtl/isingm_checker.sv
module isingm_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_stall,
	input logic                                    out_valid,
	input logic                                    out_stall,
	input logic                                    accepted,
	input logic                                    spin_after,
	input logic signed [isingm_pkg::ENERGY_W-1:0]  energy
);

	// held result stays put until transferred
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(accepted) &&
			$stable(spin_after) && $stable(energy))
		else $error("result changed while stalled");

	// one item in flight: an input transfer closes the input side
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in flight");

	// a fresh result only comes out of a busy cycle
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

endmodule

bind ising_metropolis_spin_update isingm_checker u_isingm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.accepted   (accepted),
	.spin_after (spin_after),
	.energy     (energy)
);

### tb/ising_metropolis_spin_update_tb.sv
module ising_metropolis_spin_update_tb;

	localparam int SIDE = isingm_pkg::SIDE_DEFAULT;
	localparam int SITES = SIDE * SIDE;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [isingm_pkg::THR_W-1:0] THR_MAX = {isingm_pkg::THR_W{1'b1}};
	localparam int STUCK_LIMIT = 40000;
	localparam int PHASE_ITEMS = 325;
	localparam int DIR_RIGHT = 0;
	localparam int DIR_LEFT = 1;
	localparam int DIR_UP = 2;
	localparam int DIR_DOWN = 3;

	typedef struct {
		logic [1:0]                    op;
		logic [isingm_pkg::SITE_W-1:0] site;
		logic                          spin;
		logic [isingm_pkg::FRAC_W-1:0] frac;
		bit                            drain_first;
	} spin_op_t;

	typedef struct packed {
		logic                                   accepted;
		logic                                   spin;
		logic signed [isingm_pkg::ENERGY_W-1:0] energy;
	} spin_update_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   in_valid = 1'b0;
	logic                                   in_stall;
	logic [1:0]                             operation = isingm_pkg::OP_WRITE;
	logic [isingm_pkg::SITE_W-1:0]          site = '0;
	logic                                   spin_value = 1'b0;
	logic [isingm_pkg::FRAC_W-1:0]          random_fraction = '0;
	logic                                   out_valid;
	logic                                   out_stall = 1'b0;
	logic                                   accepted;
	logic                                   spin_after;
	logic signed [isingm_pkg::ENERGY_W-1:0] energy;
	logic                                   psel = 1'b0;
	logic                                   penable = 1'b0;
	logic                                   pwrite = 1'b0;
	logic [isingm_pkg::CFG_ADDR_W-1:0]      paddr = '0;
	logic [isingm_pkg::CFG_DATA_W-1:0]      pwdata = '0;
	logic [isingm_pkg::CFG_DATA_W-1:0]      prdata;
	logic                                   pready;

	ising_metropolis_spin_update #(.SIDE(SIDE)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.site(site),
		.spin_value(spin_value),
		.random_fraction(random_fraction),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.spin_after(spin_after),
		.energy(energy),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// lattice and energy as the block should hold them
	bit                           lattice [SITES];
	int                           energy_run;
	logic [isingm_pkg::THR_W-1:0] thr_model [isingm_pkg::NUM_THR];

	spin_op_t     spin_ops [$];
	spin_update_t predicted_updates [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	int items_in = 0;
	int results_checked = 0;
	int flips_taken = 0;
	int recomputes = 0;
	int sat_hits = 0;
	int stuck_cycles = 0;

	initial forever #5 clk = ~clk;

	function automatic int nbr(int s, int dir);
		int row, col;
		row = s / SIDE;
		col = s % SIDE;
		case (dir)
			DIR_RIGHT: col = (col + 1) % SIDE;
			DIR_LEFT:  col = (col + SIDE - 1) % SIDE;
			DIR_UP:    row = (row + SIDE - 1) % SIDE;
			default:   row = (row + 1) % SIDE;
		endcase
		return row * SIDE + col;
	endfunction

	function automatic int bond(bit a, bit b);
		return (a == b) ? 1 : -1;
	endfunction

	function automatic int clamp_energy(int e);
		if (e < isingm_pkg::ENERGY_MIN) begin
			sat_hits++;
			return isingm_pkg::ENERGY_MIN;
		end
		if (e > isingm_pkg::ENERGY_MAX) begin
			sat_hits++;
			return isingm_pkg::ENERGY_MAX;
		end
		return e;
	endfunction

	function automatic spin_update_t metropolis_step(logic [1:0] op, int s, bit wval,
			logic [isingm_pkg::FRAC_W-1:0] frac);
		spin_update_t r;
		int sum, contr, i;
		bit cur, take;
		r = '0;
		case (op)
			isingm_pkg::OP_RECOMPUTE: begin
				sum = 0;
				for (i = 0; i < SITES; i++)
					sum += bond(lattice[i], lattice[nbr(i, DIR_RIGHT)])
						+ bond(lattice[i], lattice[nbr(i, DIR_DOWN)]);
				energy_run = clamp_energy(-sum);
				recomputes++;
			end
			isingm_pkg::OP_WRITE: lattice[s] = wval;
			isingm_pkg::OP_ATTEMPT: begin
				cur = lattice[s];
				contr = 0;
				for (i = DIR_RIGHT; i <= DIR_DOWN; i++)
					contr += bond(cur, lattice[nbr(s, i)]);
				case (contr)
					-4: take = {1'b0, frac} < thr_model[isingm_pkg::REG_THR_M4];
					-2: take = {1'b0, frac} < thr_model[isingm_pkg::REG_THR_M2];
					2:  take = {1'b0, frac} < thr_model[isingm_pkg::REG_THR_P2];
					4:  take = {1'b0, frac} < thr_model[isingm_pkg::REG_THR_P4];
					default: take = 1'b1;
				endcase
				if (take) begin
					lattice[s] = !cur;
					energy_run = clamp_energy(energy_run + 2 * contr);
					r.accepted = 1'b1;
					flips_taken++;
				end
			end
			default: ;
		endcase
		r.spin = lattice[s];
		r.energy = energy_run[isingm_pkg::ENERGY_W-1:0];
		return r;
	endfunction

	task automatic note_failure(string msg);
		if (fail_count < 10)
			$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic push_op(logic [1:0] op, int s, bit v, logic [isingm_pkg::FRAC_W-1:0] f,
			bit drain);
		spin_op_t it;
		it.op = op;
		it.site = s[isingm_pkg::SITE_W-1:0];
		it.spin = v;
		it.frac = f;
		it.drain_first = drain;
		spin_ops.push_back(it);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (spin_ops.size() != 0 || in_valid || predicted_updates.size() != 0);
	endtask

	task automatic write_threshold(isingm_pkg::thr_reg_t idx,
			logic [isingm_pkg::THR_W-1:0] value);
		logic [isingm_pkg::CFG_DATA_W-isingm_pkg::THR_W-1:0] junk;
		junk = (isingm_pkg::CFG_DATA_W - isingm_pkg::THR_W)'($urandom);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= {junk, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		thr_model[idx] = value;
	endtask

	// edges and a dense corner block make writes and attempts meet across the wrap
	function automatic int pick_site();
		int k;
		k = $urandom_range(SIDE - 1);
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(3))
					0: return k;
					1: return (SIDE - 1) * SIDE + k;
					2: return k * SIDE;
					default: return k * SIDE + SIDE - 1;
				endcase
			end
			1: return $urandom_range(3) * SIDE + $urandom_range(3);
			default: return $urandom_range(SITES - 1);
		endcase
	endfunction

	function automatic logic [isingm_pkg::FRAC_W-1:0] pick_fraction();
		logic [isingm_pkg::THR_W-1:0] t;
		t = thr_model[$urandom_range(isingm_pkg::NUM_THR - 1)];
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4: begin
				if (t[isingm_pkg::THR_W-1])
					return $urandom;
				return t[isingm_pkg::FRAC_W-1:0] - $urandom_range(1);
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_random_items(int count);
		int start, c, k, r;
		start = spin_ops.size();
		while (spin_ops.size() - start < count) begin
			c = pick_site();
			if ($urandom_range(9) < 4) begin
				// shape a neighborhood, then try the center a few times
				for (k = DIR_RIGHT; k <= DIR_DOWN; k++)
					if ($urandom_range(1))
						push_op(isingm_pkg::OP_WRITE, nbr(c, k), 1'($urandom_range(1)),
							$urandom, 1'b0);
				if ($urandom_range(1))
					push_op(isingm_pkg::OP_WRITE, c, 1'($urandom_range(1)), $urandom, 1'b0);
				repeat ($urandom_range(1, 3))
					push_op(isingm_pkg::OP_ATTEMPT, c, 1'($urandom_range(1)),
						pick_fraction(), 1'b0);
			end else begin
				r = $urandom_range(999);
				if (r < 30)
					push_op(isingm_pkg::OP_RECOMPUTE, c, 1'($urandom_range(1)), $urandom,
						1'b0);
				else if (r < 70)
					push_op(OP_UNUSED, c, 1'($urandom_range(1)), $urandom,
						$urandom_range(99) == 0);
				else if (r < 400)
					push_op(isingm_pkg::OP_WRITE, c, 1'($urandom_range(1)), $urandom,
						$urandom_range(99) == 0);
				else
					push_op(isingm_pkg::OP_ATTEMPT, c, 1'($urandom_range(1)),
						pick_fraction(), $urandom_range(99) == 0);
			end
		end
	endtask

	// input side: predict on each transfer, then offer the next item
	always @(posedge clk) begin : feed
		spin_op_t nxt;
		bit launch;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted_updates.push_back(metropolis_step(operation, int'(site),
					spin_value, random_fraction));
				items_in++;
			end
			if (!in_valid || !in_stall) begin
				launch = spin_ops.size() != 0 && $urandom_range(99) >= send_idle_pct;
				if (launch && spin_ops[0].drain_first && predicted_updates.size() != 0)
					launch = 1'b0;
				if (launch) begin
					nxt = spin_ops.pop_front();
					operation <= nxt.op;
					site <= nxt.site;
					spin_value <= nxt.spin;
					random_fraction <= nxt.frac;
				end
				in_valid <= launch;
			end
		end
	end

	always @(posedge clk) begin : check
		spin_update_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_updates.size() == 0) begin
					note_failure($sformatf(
						"result with nothing pending: accepted=%0b spin_after=%0b energy=%0d",
						accepted, spin_after, energy));
				end else begin
					want = predicted_updates.pop_front();
					results_checked++;
					if (accepted !== want.accepted || spin_after !== want.spin
							|| energy !== want.energy)
						note_failure($sformatf({"result %0d: accepted exp %0b got %0b, ",
							"spin_after exp %0b got %0b, energy exp %0d got %0d"},
							results_checked, want.accepted, accepted, want.spin, spin_after,
							want.energy, energy));
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("no transfer on either side for %0d cycles", STUCK_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin : stimulus
		int k, p;
		foreach (lattice[i])
			lattice[i] = 1'b1;
		energy_run = clamp_energy(-2 * SITES);
		foreach (thr_model[i])
			thr_model[i] = isingm_pkg::THR_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed part; registers written while the block clears its lattice
		write_threshold(isingm_pkg::REG_THR_M4, '0);
		write_threshold(isingm_pkg::REG_THR_M2, THR_MAX);
		write_threshold(isingm_pkg::REG_THR_P2, isingm_pkg::THR_RESET);
		write_threshold(isingm_pkg::REG_THR_P4, 33'h0_8000_0000);
		send_idle_pct = 7;
		recv_stall_pct = 7;
		push_op(isingm_pkg::OP_ATTEMPT, 0, 1'b0, 32'hFFFF_FFFF, 1'b0);
		push_op(isingm_pkg::OP_ATTEMPT, 0, 1'b1, 32'h7FFF_FFFF, 1'b0);
		push_op(isingm_pkg::OP_ATTEMPT, 0, 1'b0, 32'h0, 1'b0);
		push_op(isingm_pkg::OP_WRITE, 0, 1'b1, 32'h0, 1'b0);
		push_op(isingm_pkg::OP_RECOMPUTE, SITES - 1, 1'b1, 32'hFFFF_FFFF, 1'b0);
		push_op(isingm_pkg::OP_ATTEMPT, SITES - 1, 1'b0, 32'h8000_0000, 1'b0);
		push_op(isingm_pkg::OP_WRITE, SIDE - 1, 1'b0, 32'h0, 1'b0);
		push_op(isingm_pkg::OP_ATTEMPT, 0, 1'b0, 32'hFFFF_FFFF, 1'b0);
		push_op(isingm_pkg::OP_ATTEMPT, 0, 1'b0, 32'hFFFF_FFFF, 1'b0);
		push_op(isingm_pkg::OP_WRITE, (SIDE - 1) * SIDE, 1'b0, 32'h0, 1'b0);
		push_op(isingm_pkg::OP_ATTEMPT, 0, 1'b1, 32'hFFFF_FFFF, 1'b0);
		push_op(OP_UNUSED, SIDE - 1, 1'b1, 32'hFFFF_FFFF, 1'b0);
		push_op(isingm_pkg::OP_WRITE, SITES - 1, 1'b0, 32'h0, 1'b0);
		push_op(isingm_pkg::OP_ATTEMPT, SITES - 1, 1'b0, 32'h0, 1'b0);
		push_op(isingm_pkg::OP_RECOMPUTE, 0, 1'b0, 32'h0, 1'b1);
		push_op(OP_UNUSED, SITES - 1, 1'b0, 32'h0, 1'b0);
		push_op(isingm_pkg::OP_ATTEMPT, SITES / 2 + SIDE / 2, 1'b1, 32'h7FFF_FFFF, 1'b0);
		push_op(isingm_pkg::OP_ATTEMPT, 1, 1'b1, 32'h8000_0000, 1'b0);
		wait_idle();

		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin
					write_threshold(isingm_pkg::REG_THR_M4, isingm_pkg::THR_RESET);
					write_threshold(isingm_pkg::REG_THR_M2, isingm_pkg::THR_RESET);
					write_threshold(isingm_pkg::REG_THR_P2, {1'b0, 32'($urandom)});
					write_threshold(isingm_pkg::REG_THR_P4,
						{1'b0, 32'($urandom_range(32'h4000_0000))});
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					for (k = 0; k < isingm_pkg::NUM_THR; k++)
						write_threshold(isingm_pkg::thr_reg_t'(k), '0);
					send_idle_pct = 62;
					recv_stall_pct = 0;
				end
				2: begin
					for (k = 0; k < isingm_pkg::NUM_THR; k++)
						write_threshold(isingm_pkg::thr_reg_t'(k), THR_MAX);
					send_idle_pct = 0;
					recv_stall_pct = 62;
				end
				default: begin
					for (k = 0; k < isingm_pkg::NUM_THR; k++)
						write_threshold(isingm_pkg::thr_reg_t'(k),
							{1'($urandom_range(1)), 32'($urandom)});
					send_idle_pct = 7;
					recv_stall_pct = 7;
				end
			endcase
			queue_random_items(PHASE_ITEMS);
			wait_idle();
		end

		repeat (50) @(posedge clk);
		$display("%0d spin operations sent, %0d results compared; %0d flips taken, %0d %s",
			items_in, results_checked, flips_taken, recomputes, "recomputes.");
		$display("Four idling mixes, threshold sets from zero to full scale; %0d %s",
			sat_hits, "energy clamps.");
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d failures", fail_count);
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
